// ----- hw/rtl/dva_pkg.sv -----
// Shared types, constants and calendar helpers for the date check and day adder.
package dva_pkg;

   localparam int YEAR_WIDTH = 14;
   localparam int ADD_WIDTH  = 16;
   localparam int REM_WIDTH  = 9;

   localparam logic [REM_WIDTH-1:0] YEAR_CYCLE   = 9'd400;
   localparam logic [REM_WIDTH-1:0] CENTURY_1    = 9'd100;
   localparam logic [REM_WIDTH-1:0] CENTURY_2    = 9'd200;
   localparam logic [REM_WIDTH-1:0] CENTURY_3    = 9'd300;
   localparam logic [REM_WIDTH-1:0] CYCLE_LAST   = 9'd399;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] LEN_LONG  = 5'd31;
   localparam logic [4:0] LEN_SHORT = 5'd30;
   localparam logic [4:0] LEN_LEAP  = 5'd29;
   localparam logic [4:0] LEN_FEB   = 5'd28;

   typedef struct packed {
      logic [4:0]            start_day;
      logic [3:0]            start_month;
      logic [YEAR_WIDTH-1:0] start_year;
      logic [ADD_WIDTH-1:0]  days_to_add;
   } dva_req_type;

   typedef struct packed {
      logic                  date_ok;
      logic [4:0]            due_day;
      logic [3:0]            due_month;
      logic [YEAR_WIDTH-1:0] due_year;
   } dva_rsp_type;

   typedef struct packed {
      logic                 done;
      logic [REM_WIDTH-1:0] rem;
   } dva_mod_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_STEP,
      ST_DONE
   } dva_state_type;

   function automatic logic leap_of(input logic [REM_WIDTH-1:0] rem);
      logic leap;
      if (rem == '0) begin
         leap = 1'b1;
      end else if (rem == CENTURY_1 || rem == CENTURY_2 || rem == CENTURY_3) begin
         leap = 1'b0;
      end else begin
         leap = (rem[1:0] == 2'b00);
      end
      return leap;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      if (month == MONTH_FEB) begin
         len = leap ? LEN_LEAP : LEN_FEB;
      end else if (month == MONTH_APR || month == MONTH_JUN ||
                   month == MONTH_SEP || month == MONTH_NOV) begin
         len = LEN_SHORT;
      end else begin
         len = LEN_LONG;
      end
      return len;
   endfunction

endpackage

// ----- hw/rtl/dva_mod400.sv -----
// Remainder of the year by 400 from a reciprocal multiply.
module dva_mod400 import dva_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [YEAR_WIDTH-1:0] year,
   output dva_mod_status_type    status
);

   // quotient = (year * ceil(2^28 / 400)) >> 28, exact for years up to 20 bits
   localparam int RECIP_WIDTH = 20;
   localparam int RECIP_SHIFT = 28;
   localparam int PROD_WIDTH  = YEAR_WIDTH + RECIP_WIDTH;
   // 400 exceeds 2^8, so the quotient needs 8 bits fewer than the year
   localparam int QUOT_WIDTH  = YEAR_WIDTH - 8;
   localparam logic [RECIP_WIDTH-1:0] RECIP_400 = 20'd671089;

   logic                  load_ff, load_in;
   logic                  mul_ff, mul_in;
   logic                  done_ff, done_in;
   logic [YEAR_WIDTH-1:0] year_ff, year_in;
   logic [QUOT_WIDTH-1:0] quot_ff, quot_in;
   logic [REM_WIDTH-1:0]  rem_ff, rem_in;
   logic [PROD_WIDTH-1:0] prod;
   logic [YEAR_WIDTH-1:0] diff;

   always_comb begin
      prod    = PROD_WIDTH'(year_ff) * PROD_WIDTH'(RECIP_400);
      diff    = year_ff - YEAR_WIDTH'(quot_ff) * YEAR_WIDTH'(YEAR_CYCLE);
      load_in = start;
      mul_in  = load_ff;
      done_in = mul_ff;
      year_in = start ? year : year_ff;
      quot_in = load_ff ? prod[RECIP_SHIFT +: QUOT_WIDTH] : quot_ff;
      rem_in  = mul_ff ? diff[REM_WIDTH-1:0] : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
      year_ff <= year_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

// ----- hw/rtl/date_validate_add_days.sv -----
// Gregorian date check and day addition, top level.
//
// Command port: a transfer is taken on a rising edge with start high and busy
// low; req_data carries the start date and the day count. busy stays high
// until the result has been shown.
// Result port: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver cannot stall, so the result is taken in that cycle. An invalid
// start date gives date_ok low and all date fields zero.
// Sequence: the year remainder by 400 in the reciprocal multiply unit, a
// hand-over of it, the check, and one month walker step per month crossed,
// plus a last step when the count ends inside a month.
// One item at a time; the next command is taken in the cycle after the result.
// Reset: synchronous, clears the sequencer to idle with busy low; no result
// is pending afterward.
module date_validate_add_days import dva_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dva_req_type req_data,
   output logic        rsp_valid,
   output dva_rsp_type rsp_data
);

   dva_state_type         state_ff, state_in;
   logic [4:0]            day_ff, day_in;
   logic [3:0]            month_ff, month_in;
   logic [YEAR_WIDTH-1:0] year_ff, year_in;
   logic [ADD_WIDTH-1:0]  left_ff, left_in;
   logic [REM_WIDTH-1:0]  rem_ff, rem_in;
   logic                  ok_ff, ok_in;
   logic                  mod_start;
   dva_mod_status_type    mod_status;
   logic [4:0]            len;
   logic [ADD_WIDTH-1:0]  avail;

   dva_mod400 u_mod400 (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .year   (req_data.start_year),
      .status (mod_status)
   );

   always_comb begin
      len       = month_len(month_ff, leap_of(rem_ff));
      avail     = ADD_WIDTH'(len - day_ff) + 1'b1;
      state_in  = state_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      left_in   = left_ff;
      rem_in    = rem_ff;
      ok_in     = ok_ff;
      mod_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mod_start = 1'b1;
               day_in    = req_data.start_day;
               month_in  = req_data.start_month;
               year_in   = req_data.start_year;
               left_in   = req_data.days_to_add;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_status.done) begin
               rem_in   = mod_status.rem;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (month_ff < MONTH_JAN || month_ff > MONTH_DEC ||
                day_ff == '0 || day_ff > len) begin
               ok_in    = 1'b0;
               state_in = ST_DONE;
            end else begin
               ok_in    = 1'b1;
               state_in = (left_ff == '0) ? ST_DONE : ST_STEP;
            end
         end
         ST_STEP: begin
            if (left_ff >= avail) begin
               left_in = left_ff - avail;
               day_in  = 5'd1;
               if (month_ff == MONTH_DEC) begin
                  month_in = MONTH_JAN;
                  year_in  = year_ff + 1'b1;
                  if (year_ff == '1) begin
                     rem_in = '0;
                  end else if (rem_ff == CYCLE_LAST) begin
                     rem_in = '0;
                  end else begin
                     rem_in = rem_ff + 1'b1;
                  end
               end else begin
                  month_in = month_ff + 1'b1;
               end
               if (left_ff == avail) begin
                  state_in = ST_DONE;
               end
            end else begin
               day_in   = day_ff + left_ff[4:0];
               left_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      left_ff  <= left_in;
      rem_ff   <= rem_in;
      ok_ff    <= ok_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_DONE);
   assign rsp_data.date_ok   = ok_ff;
   assign rsp_data.due_day   = ok_ff ? day_ff : '0;
   assign rsp_data.due_month = ok_ff ? month_ff : '0;
   assign rsp_data.due_year  = ok_ff ? year_ff : '0;

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy window");

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("block did not return to idle after result");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && !rsp_valid)
      else $error("accepted command did not raise busy");

   a_valid_month: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.date_ok) |->
         (rsp_data.due_month >= MONTH_JAN && rsp_data.due_month <= MONTH_DEC &&
          rsp_data.due_day != '0))
      else $error("valid result with out of range date");

endmodule

// ----- verif/tb.sv -----
// Testbench for date_validate_add_days: directed table and random dates checked against a predictor.
`timescale 1ns / 1ps

module tb import dva_pkg::*; ();

   typedef struct {
      int day, month, year, count;
      int typed, ok, dd, dm, dy;
   } date_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   dva_req_type req_data;
   logic        rsp_valid;
   dva_rsp_type rsp_data;

   dva_rsp_type  due_q[$];
   dva_rsp_type  due_want;
   date_row_type dir_rows[$];
   int           bad_count = 0;
   bit           idle_on = 1'b1;

   date_validate_add_days u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic bit is_leap(input int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
      if (m == MONTH_FEB) return is_leap(y) ? 29 : 28;
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return 30;
      return 31;
   endfunction

   function automatic dva_rsp_type calc_due_date(input dva_req_type r);
      int unsigned d, m, y, left, len;
      dva_rsp_type due;
      d    = 32'(r.start_day);
      m    = 32'(r.start_month);
      y    = 32'(r.start_year);
      left = 32'(r.days_to_add);
      due  = '0;
      if (m < MONTH_JAN || m > MONTH_DEC || d < 1 || d > days_in(m, y)) return due;
      while (left > 0) begin
         len = days_in(m, y);
         if (d + left > len) begin
            left = left - (len - d + 1);
            d = 1;
            if (m == MONTH_DEC) begin
               m = MONTH_JAN;
               y = (y + 1) % (1 << YEAR_WIDTH);
            end else begin
               m = m + 1;
            end
         end else begin
            d = d + left;
            left = 0;
         end
      end
      due.date_ok   = 1'b1;
      due.due_day   = 5'(d);
      due.due_month = 4'(m);
      due.due_year  = YEAR_WIDTH'(y);
      return due;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic dva_req_type rand_date();
      int unsigned d, m, y, pick;
      dva_req_type r;
      pick = $urandom_range(0, 99);
      if (pick < 40) y = $urandom_range(0, 9999);
      else if (pick < 60) y = $urandom_range(0, 40) * 400 + $urandom_range(0, 3) * 100;
      else if (pick < 75) y = $urandom_range(16300, 16383);
      else y = $urandom_range(0, 16383);
      y = y % (1 << YEAR_WIDTH);
      if ($urandom_range(0, 99) < 75) begin
         m = $urandom_range(MONTH_JAN, MONTH_DEC);
         d = ($urandom_range(0, 9) < 3) ? days_in(m, y) : $urandom_range(1, days_in(m, y));
      end else begin
         m = $urandom_range(0, 15);
         d = $urandom_range(0, 31);
      end
      r.start_day   = 5'(d);
      r.start_month = 4'(m);
      r.start_year  = YEAR_WIDTH'(y);
      pick = $urandom_range(0, 99);
      if (pick < 50) r.days_to_add = ADD_WIDTH'($urandom_range(0, 60));
      else if (pick < 75) r.days_to_add = ADD_WIDTH'($urandom_range(0, 1500));
      else if (pick < 92) r.days_to_add = ADD_WIDTH'($urandom_range(0, 65535));
      else r.days_to_add = ADD_WIDTH'(32'hFFFF - $urandom_range(0, 1));
      return r;
   endfunction

   task automatic send_date(input dva_req_type r, input bit typed, input dva_rsp_type typed_due,
                            input bit drain);
      int gap;
      gap = pick_gap();
      if (drain && gap == 0) gap = 1;
      if (gap > 0) begin
         start <= 1'b0;
         while (drain && due_q.size() != 0) @(posedge clock);
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      due_q.push_back(typed ? typed_due : calc_due_date(r));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_q.size() == 0) begin
            $display("%0t: unexpected result ok=%0d %0d/%0d/%0d", $time, rsp_data.date_ok,
                     rsp_data.due_day, rsp_data.due_month, rsp_data.due_year);
            bad_count++;
         end else begin
            due_want = due_q.pop_front();
            if (rsp_data.date_ok !== due_want.date_ok || rsp_data.due_day !== due_want.due_day ||
                rsp_data.due_month !== due_want.due_month ||
                rsp_data.due_year !== due_want.due_year) begin
               $display("%0t: mismatch expected ok=%0d %0d/%0d/%0d actual ok=%0d %0d/%0d/%0d",
                        $time, due_want.date_ok, due_want.due_day, due_want.due_month,
                        due_want.due_year, rsp_data.date_ok, rsp_data.due_day,
                        rsp_data.due_month, rsp_data.due_year);
               bad_count++;
            end
         end
      end
   end

   initial begin
      dva_req_type r;
      dva_rsp_type d;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;

      dir_rows.push_back('{1, 1, 2000, 0, 1, 1, 1, 1, 2000});
      dir_rows.push_back('{0, 5, 2020, 10, 1, 0, 0, 0, 0});
      dir_rows.push_back('{15, 0, 2020, 5, 1, 0, 0, 0, 0});
      dir_rows.push_back('{10, 13, 2020, 5, 1, 0, 0, 0, 0});
      dir_rows.push_back('{31, 15, 16383, 65535, 1, 0, 0, 0, 0});
      dir_rows.push_back('{31, 4, 2021, 1, 1, 0, 0, 0, 0});
      dir_rows.push_back('{29, 2, 1900, 0, 1, 0, 0, 0, 0});
      dir_rows.push_back('{29, 2, 2100, 3, 1, 0, 0, 0, 0});
      dir_rows.push_back('{29, 2, 2000, 0, 1, 1, 29, 2, 2000});
      dir_rows.push_back('{29, 2, 2024, 1, 1, 1, 1, 3, 2024});
      dir_rows.push_back('{28, 2, 2100, 1, 1, 1, 1, 3, 2100});
      dir_rows.push_back('{28, 2, 2023, 1, 1, 1, 1, 3, 2023});
      dir_rows.push_back('{31, 12, 1999, 1, 1, 1, 1, 1, 2000});
      dir_rows.push_back('{29, 2, 0, 0, 1, 1, 29, 2, 0});
      dir_rows.push_back('{31, 12, 16383, 1, 1, 1, 1, 1, 0});
      dir_rows.push_back('{30, 6, 2022, 1, 1, 1, 1, 7, 2022});
      dir_rows.push_back('{1, 1, 2000, 65535, 0, 0, 0, 0, 0});
      dir_rows.push_back('{31, 1, 2023, 29, 0, 0, 0, 0, 0});
      dir_rows.push_back('{31, 12, 9999, 65535, 0, 0, 0, 0, 0});
      dir_rows.push_back('{1, 1, 16383, 65535, 0, 0, 0, 0, 0});
      dir_rows.push_back('{31, 10, 16383, 365, 0, 0, 0, 0, 0});
      dir_rows.push_back('{15, 8, 1600, 1000, 0, 0, 0, 0, 0});
      dir_rows.push_back('{1, 3, 0, 65534, 0, 0, 0, 0, 0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         r.start_day   = 5'(dir_rows[i].day);
         r.start_month = 4'(dir_rows[i].month);
         r.start_year  = YEAR_WIDTH'(dir_rows[i].year);
         r.days_to_add = ADD_WIDTH'(dir_rows[i].count);
         d.date_ok     = 1'(dir_rows[i].ok);
         d.due_day     = 5'(dir_rows[i].dd);
         d.due_month   = 4'(dir_rows[i].dm);
         d.due_year    = YEAR_WIDTH'(dir_rows[i].dy);
         send_date(r, dir_rows[i].typed != 0, d, 1'b0);
      end

      for (int i = 0; i < 250; i++) begin
         idle_on = (i < 80 || i >= 130);
         send_date(rand_date(), 1'b0, '0, i == 160);
      end
      start <= 1'b0;

      while (due_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (bad_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/dva_pkg.sv
hw/rtl/dva_mod400.sv
hw/rtl/date_validate_add_days.sv
verif/tb.sv
